FILE: sv/natwa_pkg.sv
// Shared constants, codes and control/status types of the node address table.
package natwa_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned MARK_W      = 5;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned EV_W       = 3;
  localparam int unsigned IDX_OUT_W  = 4;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [TIME_W-1:0] OFFLINE_TIMEOUT_RST = 32'd90000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_TIMEOUT = 1'b1;

  // item commands
  localparam logic [CMD_W-1:0] CMD_HELLO  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // result events
  localparam logic [EV_W-1:0] EV_REFRESHED  = 3'd0;
  localparam logic [EV_W-1:0] EV_ADDED      = 3'd1;
  localparam logic [EV_W-1:0] EV_BACK       = 3'd2;
  localparam logic [EV_W-1:0] EV_FULL       = 3'd3;
  localparam logic [EV_W-1:0] EV_OWN        = 3'd4;
  localparam logic [EV_W-1:0] EV_OFFLINE    = 3'd5;
  localparam logic [EV_W-1:0] EV_LOOKUP     = 3'd6;
  localparam logic [EV_W-1:0] EV_SWEEP_NONE = 3'd7;

  typedef enum logic [3:0] {
    RK_OWN,
    RK_REFRESH,
    RK_APPEND,
    RK_FULL,
    RK_HIT,
    RK_MISS,
    RK_PEND_MID,
    RK_PEND_LAST,
    RK_SWEEP_NONE
  } res_kind_e;

  typedef struct packed {
    logic      cap;   // capture the accepted item
    logic      clr;   // restart the walk
    logic      rd;    // read entry at the walk pointer
    logic      take;  // consume the entry under check
    logic      mark;  // mark checked entry offline and hold it as pending
    logic      load;  // load the result register
    res_kind_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             own_hit;
    logic             p_end;
    logic             b_vld;
    logic             b_match;
    logic             b_expire;
    logic             full;
    logic             out_free;
    logic             pend_vld;
    logic             mark_lim;
  } dp_stat_t;

endpackage

FILE: sv/natwa_dp.sv
// Datapath: configuration, table memories, entry walk, compare logic and result register.
module natwa_dp #(
  parameter int unsigned TableDepth = natwa_pkg::TABLE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [natwa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [natwa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [natwa_pkg::CMD_W-1:0]         in_cmd_i,
  input  logic [natwa_pkg::ADDR_W-1:0]        in_addr_i,
  input  logic [natwa_pkg::TIME_W-1:0]        in_now_i,
  input  natwa_pkg::ctrl_cmd_t                cmd_i,
  output natwa_pkg::dp_stat_t                 stat_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [natwa_pkg::EV_W-1:0]          out_event_o,
  output logic                                out_found_o,
  output logic [natwa_pkg::IDX_OUT_W-1:0]     out_index_o,
  output logic                                out_active_o,
  output logic                                out_last_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned AW   = natwa_pkg::ADDR_W;
  localparam int unsigned TW   = natwa_pkg::TIME_W;
  localparam int unsigned MW   = natwa_pkg::MARK_W;
  localparam int unsigned OW   = natwa_pkg::IDX_OUT_W;

  logic [AW-1:0] own_q;
  logic [TW-1:0] tmo_q;

  logic [natwa_pkg::CMD_W-1:0] cmd_q;
  logic [AW-1:0]               addr_q;
  logic [TW-1:0]               now_q;

  logic [AW-1:0] addr_mem [TableDepth];
  logic [TW-1:0] time_mem [TableDepth];

  logic [TableDepth-1:0] active_q;
  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       ptr_q;
  logic                  b_vld_q;
  logic [IdxW-1:0]       b_idx_q;
  logic [AW-1:0]         b_addr_q;
  logic [TW-1:0]         b_time_q;
  logic                  pend_vld_q;
  logic [IdxW-1:0]       pend_idx_q;
  logic [MW-1:0]         marks_q;

  logic                       out_vld_q;
  logic [natwa_pkg::EV_W-1:0] out_ev_q;
  logic                       out_found_q;
  logic [OW-1:0]              out_idx_q;
  logic                       out_act_q;
  logic                       out_last_q;

  logic [natwa_pkg::EV_W-1:0] res_ev;
  logic                       res_found;
  logic [OW-1:0]              res_idx;
  logic                       res_act;
  logic                       res_last;

  logic            is_refresh;
  logic            is_append;
  logic [TW-1:0]   age;
  logic            out_free;

  assign is_refresh = cmd_i.load && (cmd_i.kind == natwa_pkg::RK_REFRESH);
  assign is_append  = cmd_i.load && (cmd_i.kind == natwa_pkg::RK_APPEND);
  assign age        = now_q - b_time_q;
  assign out_free   = !out_vld_q || out_ready_i;

  always_comb begin
    stat_o          = '0;
    stat_o.cmd      = cmd_q;
    stat_o.own_hit  = (addr_q == own_q);
    stat_o.p_end    = (ptr_q == count_q);
    stat_o.b_vld    = b_vld_q;
    stat_o.b_match  = (b_addr_q == addr_q);
    stat_o.b_expire = active_q[b_idx_q] && (age > tmo_q);
    stat_o.full     = (count_q == CntW'(TableDepth));
    stat_o.out_free = out_free;
    stat_o.pend_vld = pend_vld_q;
    stat_o.mark_lim = (marks_q == MW'(natwa_pkg::MAX_RESULTS - 1));
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
      tmo_q <= natwa_pkg::OFFLINE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        natwa_pkg::CFG_OWN_ADDRESS:     own_q <= cfg_data_i[AW-1:0];
        natwa_pkg::CFG_OFFLINE_TIMEOUT: tmo_q <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cmd_q  <= in_cmd_i;
      addr_q <= in_addr_i;
      now_q  <= in_now_i;
    end
  end

  // address memory
  always_ff @(posedge clk_i) begin
    if (is_append) begin
      addr_mem[count_q[IdxW-1:0]] <= addr_q;
    end
    if (cmd_i.rd) begin
      b_addr_q <= addr_mem[ptr_q[IdxW-1:0]];
    end
  end

  // last-seen time memory
  always_ff @(posedge clk_i) begin
    if (is_append) begin
      time_mem[count_q[IdxW-1:0]] <= now_q;
    end else if (is_refresh) begin
      time_mem[b_idx_q] <= now_q;
    end
    if (cmd_i.rd) begin
      b_time_q <= time_mem[ptr_q[IdxW-1:0]];
    end
  end

  // walk and table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      count_q    <= '0;
      ptr_q      <= '0;
      b_vld_q    <= 1'b0;
      b_idx_q    <= '0;
      pend_vld_q <= 1'b0;
      pend_idx_q <= '0;
      marks_q    <= '0;
    end else begin
      if (cmd_i.clr) begin
        ptr_q      <= '0;
        b_vld_q    <= 1'b0;
        pend_vld_q <= 1'b0;
        marks_q    <= '0;
      end else begin
        if (cmd_i.rd) begin
          ptr_q   <= ptr_q + CntW'(1);
          b_vld_q <= 1'b1;
          b_idx_q <= ptr_q[IdxW-1:0];
        end else if (cmd_i.take) begin
          b_vld_q <= 1'b0;
        end
        if (cmd_i.mark) begin
          pend_vld_q <= 1'b1;
          pend_idx_q <= b_idx_q;
          marks_q    <= marks_q + MW'(1);
        end
      end
      if (cmd_i.mark) begin
        active_q[b_idx_q] <= 1'b0;
      end
      if (is_refresh) begin
        active_q[b_idx_q] <= 1'b1;
      end
      if (is_append) begin
        active_q[count_q[IdxW-1:0]] <= 1'b1;
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_comb begin
    res_ev    = natwa_pkg::EV_LOOKUP;
    res_found = 1'b0;
    res_idx   = '0;
    res_act   = 1'b0;
    res_last  = 1'b1;
    case (cmd_i.kind)
      natwa_pkg::RK_OWN: res_ev = natwa_pkg::EV_OWN;
      natwa_pkg::RK_REFRESH: begin
        res_ev    = active_q[b_idx_q] ? natwa_pkg::EV_REFRESHED : natwa_pkg::EV_BACK;
        res_found = 1'b1;
        res_idx   = OW'(b_idx_q);
        res_act   = 1'b1;
      end
      natwa_pkg::RK_APPEND: begin
        res_ev    = natwa_pkg::EV_ADDED;
        res_found = 1'b1;
        res_idx   = OW'(count_q);
        res_act   = 1'b1;
      end
      natwa_pkg::RK_FULL: res_ev = natwa_pkg::EV_FULL;
      natwa_pkg::RK_HIT: begin
        res_found = 1'b1;
        res_idx   = OW'(b_idx_q);
        res_act   = active_q[b_idx_q];
      end
      natwa_pkg::RK_MISS: res_ev = natwa_pkg::EV_LOOKUP;
      natwa_pkg::RK_PEND_MID: begin
        res_ev    = natwa_pkg::EV_OFFLINE;
        res_found = 1'b1;
        res_idx   = OW'(pend_idx_q);
        res_last  = 1'b0;
      end
      natwa_pkg::RK_PEND_LAST: begin
        res_ev    = natwa_pkg::EV_OFFLINE;
        res_found = 1'b1;
        res_idx   = OW'(pend_idx_q);
      end
      natwa_pkg::RK_SWEEP_NONE: res_ev = natwa_pkg::EV_SWEEP_NONE;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_ev_q    <= res_ev;
      out_found_q <= res_found;
      out_idx_q   <= res_idx;
      out_act_q   <= res_act;
      out_last_q  <= res_last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_event_o  = out_ev_q;
  assign out_found_o  = out_found_q;
  assign out_index_o  = out_idx_q;
  assign out_active_o = out_act_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("entry count beyond table depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> out_free)
    else $error("result register overwritten while still held");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_append |-> (count_q < CntW'(TableDepth)))
    else $error("append into a full table");

  a_check_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> (CntW'(b_idx_q) < count_q))
    else $error("checked entry was never written");
`endif

endmodule

FILE: sv/natwa_ctrl.sv
// Controller: sequences capture, table walk and result loads for each item.
module natwa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  natwa_pkg::dp_stat_t  stat_i,
  output natwa_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_END
  } state_e;

  state_e state_q;
  state_e state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = natwa_pkg::RK_MISS;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_START;
        end
      end
      S_START: begin
        cmd_o.clr = 1'b1;
        case (stat_i.cmd)
          natwa_pkg::CMD_HELLO: begin
            if (stat_i.own_hit) begin
              if (stat_i.out_free) begin
                cmd_o.load = 1'b1;
                cmd_o.kind = natwa_pkg::RK_OWN;
                state_d    = S_IDLE;
              end
            end else begin
              state_d = S_SCAN;
            end
          end
          natwa_pkg::CMD_SWEEP, natwa_pkg::CMD_LOOKUP: state_d = S_SCAN;
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (stat_i.b_vld) begin
          if (stat_i.cmd != natwa_pkg::CMD_SWEEP) begin
            if (stat_i.b_match) begin
              if (stat_i.out_free) begin
                cmd_o.load = 1'b1;
                cmd_o.kind = (stat_i.cmd == natwa_pkg::CMD_HELLO) ?
                             natwa_pkg::RK_REFRESH : natwa_pkg::RK_HIT;
                state_d    = S_IDLE;
              end
            end else begin
              cmd_o.take = 1'b1;
              cmd_o.rd   = !stat_i.p_end;
            end
          end else if (stat_i.b_expire) begin
            // push the held mark before taking the new one
            if (!stat_i.pend_vld || stat_i.out_free) begin
              cmd_o.mark = 1'b1;
              cmd_o.take = 1'b1;
              if (stat_i.pend_vld) begin
                cmd_o.load = 1'b1;
                cmd_o.kind = natwa_pkg::RK_PEND_MID;
              end
              if (stat_i.mark_lim) begin
                state_d = S_END;
              end else begin
                cmd_o.rd = !stat_i.p_end;
              end
            end
          end else begin
            cmd_o.take = 1'b1;
            cmd_o.rd   = !stat_i.p_end;
          end
        end else if (stat_i.p_end) begin
          state_d = S_END;
        end else begin
          cmd_o.rd = 1'b1;
        end
      end
      S_END: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
          case (stat_i.cmd)
            natwa_pkg::CMD_HELLO:
              cmd_o.kind = stat_i.full ? natwa_pkg::RK_FULL : natwa_pkg::RK_APPEND;
            natwa_pkg::CMD_SWEEP:
              cmd_o.kind = stat_i.pend_vld ? natwa_pkg::RK_PEND_LAST
                                           : natwa_pkg::RK_SWEEP_NONE;
            default: cmd_o.kind = natwa_pkg::RK_MISS;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/node_address_table_with_aging.sv
// Top level of the node address table with aging: stream ports and config port.
// Keeps up to TableDepth 48-bit node addresses with last-seen time and active mark.
// One item is handled at a time: a hello or lookup walks the table one entry per
// cycle through the registered read port of the table memory and stops on a match.
// A hello of the own address is answered without a walk. Any result load waits
// while the output register still holds an unread result. A sweep walks all
// entries and stops early after 16 offline marks, at the entry of the 16th mark.
// Each mark is emitted when the next one is found or at the end of the walk, so
// the final result carries tlast. Results wait in an output register, so the
// next item is taken while a result is unread. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
module node_address_table_with_aging #(
  parameter int unsigned TableDepth = natwa_pkg::TABLE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [natwa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [natwa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [79:0]                       s_axis_tdata_i,  // node_address, now_ms
  input  logic [1:0]                        s_axis_tuser_i,  // command
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,  // found, entry_index,
                                                             // entry_active, zero pad
  output logic [2:0]                        m_axis_tuser_o,  // event_res
  output logic                              m_axis_tlast_o
);

  natwa_pkg::ctrl_cmd_t ctrl_cmd;
  natwa_pkg::dp_stat_t  dp_stat;

  logic       res_found;
  logic [3:0] res_idx;
  logic       res_act;

  natwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  natwa_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser_i),
    .in_addr_i    (s_axis_tdata_i[47:0]),
    .in_now_i     (s_axis_tdata_i[79:48]),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_event_o  (m_axis_tuser_o),
    .out_found_o  (res_found),
    .out_index_o  (res_idx),
    .out_active_o (res_act),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, res_act, res_idx, res_found};

endmodule
